/* rtl/heightmap_normal_generator_defines.svh */
// ----------------------------------------------------------------------------
// Heightmap normal generator assertion macros
// Shared concurrent-assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_GENERATOR_DEFINES_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_DEFINES_SVH

// assertion sampled on clk, off while reset is held
`define HNG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heightmap_normal_generator check failed");

// assertion sampled on clk, active during reset too
`define HNG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("heightmap_normal_generator check failed");

`endif

/* rtl/hng_pkg.sv */
// ----------------------------------------------------------------------------
// hng_pkg
// Types and constants shared by the heightmap normal generator modules.
// ----------------------------------------------------------------------------
package hng_pkg;

    // config register indexes
    localparam logic [1:0] REG_SPACING = 2'd0;
    localparam logic [1:0] REG_COLS    = 2'd1;
    localparam logic [1:0] REG_ROWS    = 2'd2;

    localparam logic [15:0] SPACING_RESET = 16'd1280;
    localparam logic [6:0]  COLS_RESET    = 7'd21;
    localparam logic [6:0]  ROWS_RESET    = 7'd21;

    localparam logic [15:0] Q15_POS_MAX = 16'h7FFF;

    // one interior vertex handed from front to back
    typedef struct packed {
        logic        x_neg;
        logic [15:0] x_mag;
        logic [16:0] y_mag;
        logic        z_neg;
        logic [15:0] z_mag;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        last;
    } t_job;

endpackage

/* rtl/hng_front.sv */
// ----------------------------------------------------------------------------
// hng_front
// Sample intake: line buffers, window, grid counters, difference vector.
// ----------------------------------------------------------------------------
module hng_front import hng_pkg::*; #(
    parameter int MAX_GRID = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_height,
    input  logic        i_frame_start,
    input  logic [15:0] i_spacing,
    input  logic [6:0]  i_cols,
    input  logic [6:0]  i_rows,
    input  logic        i_q_full,
    output logic        o_job_push,
    output t_job        o_job
);
    localparam int IW = $clog2(MAX_GRID);
    localparam int SW = ($clog2(MAX_GRID + 1) > 7) ? $clog2(MAX_GRID + 1) : 7;

    typedef enum logic {F_IDLE, F_WORK} t_fstate;

    t_fstate r_state;
    logic [IW-1:0] r_row, r_col;
    logic          r_done;
    logic [15:0]   r_win0, r_win1, r_left, r_h;
    logic [15:0]   r_rd_prev, r_rd_rbp;
    logic [15:0]   mem_prev [MAX_GRID];
    logic [15:0]   mem_rbp  [MAX_GRID];

    logic          acc;
    logic [IW-1:0] c_eff, c_m1, col_m1;
    logic [SW-1:0] cols, rows, row_w, col_w;
    logic          vld;
    logic signed [16:0] dx_n, dz_n;

    assign full = (r_state == F_WORK) | i_q_full;
    assign acc  = push & ~full;

    // size registers clamped to [3, MAX_GRID]
    assign cols = (i_cols < 7'd3) ? SW'(3) :
                  (SW'(i_cols) > SW'(MAX_GRID)) ? SW'(MAX_GRID) : SW'(i_cols);
    assign rows = (i_rows < 7'd3) ? SW'(3) :
                  (SW'(i_rows) > SW'(MAX_GRID)) ? SW'(MAX_GRID) : SW'(i_rows);

    assign c_eff  = i_frame_start ? '0 : r_col;
    assign c_m1   = (c_eff == '0) ? '0 : c_eff - 1'b1;
    assign col_m1 = (r_col == '0) ? '0 : r_col - 1'b1;
    assign row_w  = SW'(r_row);
    assign col_w  = SW'(r_col);

    assign vld = (row_w >= SW'(2)) && (col_w >= SW'(2)) && (row_w < rows) && (col_w < cols);

    // negated differences: x = left - right, z = below - above
    assign dx_n = $signed({r_win1[15], r_win1}) - $signed({r_rd_prev[15], r_rd_prev});
    assign dz_n = $signed({r_left[15], r_left}) - $signed({r_rd_rbp[15], r_rd_rbp});

    always_comb begin
        o_job.x_neg = dx_n[16];
        o_job.x_mag = dx_n[16] ? 16'(-dx_n) : dx_n[15:0];
        o_job.z_neg = dz_n[16];
        o_job.z_mag = dz_n[16] ? 16'(-dz_n) : dz_n[15:0];
        o_job.y_mag = {i_spacing, 1'b0};
        o_job.row   = 6'(r_row - 1'b1);
        o_job.col   = 6'(r_col - 1'b1);
        o_job.last  = (row_w == rows - SW'(1)) && (col_w == cols - SW'(1));
    end

    assign o_job_push = (r_state == F_WORK) & ~r_done & vld;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_prev <= mem_prev[c_eff];
            r_rd_rbp  <= mem_rbp[c_m1];
            r_h       <= i_height;
        end
        if ((r_state == F_WORK) && !r_done) begin
            mem_prev[r_col] <= r_h;
            if (r_col != '0) begin
                mem_rbp[col_m1] <= r_win0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_done  <= 1'b0;
            r_win0  <= '0;
            r_win1  <= '0;
            r_left  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (acc) begin
                        r_state <= F_WORK;
                        if (i_frame_start) begin
                            r_row  <= '0;
                            r_col  <= '0;
                            r_done <= 1'b0;
                        end
                    end
                end
                F_WORK: begin
                    r_state <= F_IDLE;
                    if (!r_done) begin
                        r_win1 <= r_win0;
                        r_win0 <= r_rd_prev;
                        r_left <= r_h;
                        if (col_w + SW'(1) >= cols) begin
                            r_col <= '0;
                            if (row_w + SW'(1) >= rows) begin
                                r_done <= 1'b1;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

/* rtl/hng_queue.sv */
// ----------------------------------------------------------------------------
// hng_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module hng_queue import hng_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_data [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_data[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

/* rtl/hng_back.sv */
// ----------------------------------------------------------------------------
// hng_back
// Normalizer: sum of squares, bit-serial square root, shared divider,
// result register.
// ----------------------------------------------------------------------------
module hng_back import hng_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_normal_x,
    output logic [15:0] o_normal_y,
    output logic [15:0] o_normal_z,
    output logic [5:0]  o_vertex_row,
    output logic [5:0]  o_vertex_col,
    output logic        o_last_of_frame
);
    typedef enum logic [2:0] {B_IDLE, B_SQ, B_SQRT, B_DIV, B_OUT} t_bstate;

    t_bstate     r_state;
    t_job        r_job;
    logic [1:0]  r_comp;
    logic [4:0]  r_cnt;
    logic [34:0] r_acc;
    logic [51:0] r_n, r_root, r_bit;
    logic [41:0] r_rem, r_dsh;
    logic [16:0] r_q;
    logic [15:0] r_nx, r_ny, r_nz;
    logic        r_ovalid;

    logic [16:0] m_sel;
    logic [33:0] m_sq;
    logic [51:0] sq_t;
    logic [25:0] len;
    logic        c_neg;
    logic [16:0] c_mag;
    logic [41:0] num;
    logic [41:0] rem_n;
    logic [16:0] q_n;
    logic [15:0] comp_out;

    assign empty   = ~r_ovalid;
    assign o_q_pop = (r_state == B_IDLE) & ~i_q_empty;

    always_comb begin
        case (r_comp)
            2'd0:    m_sel = {1'b0, r_job.x_mag};
            2'd1:    m_sel = r_job.y_mag;
            default: m_sel = {1'b0, r_job.z_mag};
        endcase
    end
    assign m_sq = m_sel * m_sel;
    assign sq_t = r_root + r_bit;
    assign len  = r_root[25:0];

    always_comb begin
        case (r_comp)
            2'd0:    begin c_neg = r_job.x_neg; c_mag = {1'b0, r_job.x_mag}; end
            2'd1:    begin c_neg = 1'b0;        c_mag = r_job.y_mag;         end
            default: begin c_neg = r_job.z_neg; c_mag = {1'b0, r_job.z_mag}; end
        endcase
    end
    // rounded numerator |v| * 2^23 + len/2
    assign num = {2'b0, c_mag, 23'b0} + 42'(len >> 1);

    always_comb begin
        rem_n = r_rem;
        q_n   = r_q;
        if (r_rem >= r_dsh) begin
            rem_n          = r_rem - r_dsh;
            q_n[r_cnt[3:0] == 4'd0 && r_cnt[4] ? 16 : r_cnt] = 1'b1;
        end
    end

    // sign and saturate the finished quotient
    always_comb begin
        if (c_neg) begin
            comp_out = (q_n > 17'd32768) ? 16'h8000 : 16'(-q_n);
        end else begin
            comp_out = (q_n > 17'd32767) ? Q15_POS_MAX : q_n[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && pop) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_comp  <= 2'd0;
                        r_acc   <= '0;
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    r_acc <= r_acc + 35'(m_sq);
                    if (r_comp == 2'd2) begin
                        r_n     <= {1'b0, r_acc + 35'(m_sq), 16'b0};
                        r_root  <= '0;
                        r_bit   <= 52'(1) << 50;
                        r_cnt   <= 5'd25;
                        r_state <= B_SQRT;
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                B_SQRT: begin
                    if (r_n >= sq_t) begin
                        r_n    <= r_n - sq_t;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'd0) begin
                        if (r_acc == '0) begin
                            // degenerate vector: straight up
                            r_nx    <= '0;
                            r_ny    <= Q15_POS_MAX;
                            r_nz    <= '0;
                            r_state <= B_OUT;
                        end else begin
                            r_comp  <= 2'd0;
                            r_cnt   <= 5'd16;
                            r_dsh   <= '0;
                            r_state <= B_DIV;
                        end
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                B_DIV: begin
                    if (r_cnt == 5'd16 && r_dsh != {len, 16'b0}) begin
                        // first step of a component: load operands
                        r_rem <= num;
                        r_dsh <= {len, 16'b0};
                        r_q   <= '0;
                    end else begin
                        r_rem <= rem_n;
                        r_q   <= q_n;
                        r_dsh <= r_dsh >> 1;
                        if (r_cnt == 5'd0) begin
                            case (r_comp)
                                2'd0:    r_nx <= comp_out;
                                2'd1:    r_ny <= comp_out;
                                default: r_nz <= comp_out;
                            endcase
                            r_dsh <= '0;
                            r_cnt <= 5'd16;
                            if (r_comp == 2'd2) begin
                                r_state <= B_OUT;
                            end else begin
                                r_comp <= r_comp + 2'd1;
                            end
                        end else begin
                            r_cnt <= r_cnt - 5'd1;
                        end
                    end
                end
                B_OUT: begin
                    if (!r_ovalid || pop) begin
                        o_normal_x      <= r_nx;
                        o_normal_y      <= r_ny;
                        o_normal_z      <= r_nz;
                        o_vertex_row    <= r_job.row;
                        o_vertex_col    <= r_job.col;
                        o_last_of_frame <= r_job.last;
                        r_ovalid        <= 1'b1;
                        r_dsh           <= '0;
                        r_state         <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

/* rtl/heightmap_normal_generator.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Central-difference unit normals for a streamed heightfield.
// ----------------------------------------------------------------------------
// Height samples (signed Q8.8) enter in raster order through a queue-style
// port (push/full); frame_start marks row 0, column 0 and restarts the grid.
// Every interior vertex (r,c) yields one result, produced when sample
// (r+1,c+1) arrives: the unit normal of (-dx, 2*spacing, -dz) in signed
// Q1.15, saturated, with r, c and a flag on the last vertex of the grid.
// Border samples give nothing, and samples past the end of a grid are
// dropped until the next frame_start. Results leave through empty/pop.
// Steps: the front end handles each sample as a registered line-buffer
// read, then an update, and takes no new sample in between. The normalizer
// handles one interior vertex at a time: it takes the job, accumulates the
// squared length by multiply-accumulate, runs a bit-serial square root, then
// a restoring division for each component (operand load plus 17 quotient
// steps) on one shared divider, and writes the result register. So on a
// long stream the normalizer sets the pace, plus any wait on pop; a
// two-entry queue lets the front keep taking border samples while it works.
// Config writes (grid_spacing, cols_in_use, rows_in_use) take effect at
// once and should be made while the block is idle. Sizes clamp to
// [3, MAX_GRID]. Line buffers are not cleared by reset; after reset the
// count starts at row 0, column 0 even without frame_start, and each
// interior vertex only reads entries written earlier in its own grid.
// ----------------------------------------------------------------------------
module heightmap_normal_generator import hng_pkg::*; #(
    parameter int MAX_GRID = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample side
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_height,
    input  logic        i_frame_start,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_normal_x,
    output logic [15:0] o_normal_y,
    output logic [15:0] o_normal_z,
    output logic [5:0]  o_vertex_row,
    output logic [5:0]  o_vertex_col,
    output logic        o_last_of_frame,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    logic [15:0] r_spacing;
    logic [6:0]  r_cols, r_rows;

    logic job_push, q_full, q_empty, q_pop;
    t_job job_in, job_out;

    // config registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET;
            r_cols    <= COLS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPACING: r_spacing <= i_cfg_wdata;
                REG_COLS:    r_cols    <= i_cfg_wdata[6:0];
                REG_ROWS:    r_rows    <= i_cfg_wdata[6:0];
                default:     ;
            endcase
        end
    end

    // front: window, line buffers, difference vector per interior vertex
    hng_front #(.MAX_GRID(MAX_GRID)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_height     (i_height),
        .i_frame_start(i_frame_start),
        .i_spacing    (r_spacing),
        .i_cols       (r_cols),
        .i_rows       (r_rows),
        .i_q_full     (q_full),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    // decoupling queue
    hng_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_job  (job_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_job  (job_out)
    );

    // back: normalize and hold the result
    hng_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_job          (job_out),
        .o_q_pop        (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_vertex_row   (o_vertex_row),
        .o_vertex_col   (o_vertex_col),
        .o_last_of_frame(o_last_of_frame)
    );
endmodule

/* rtl/hng_checker.sv */
// ----------------------------------------------------------------------------
// hng_checker
// Port-level checks for the heightmap normal generator, bound to the top.
// ----------------------------------------------------------------------------
`include "heightmap_normal_generator_defines.svh"

module hng_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_normal_x,
    input logic [15:0] o_normal_y,
    input logic [15:0] o_normal_z,
    input logic [5:0]  o_vertex_row,
    input logic [5:0]  o_vertex_col
);
    // nothing pending right after reset
    `HNG_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> empty)

    // a waiting result stays pending and keeps its x and z until taken
    `HNG_ASSERT(a_hold, i_clk, i_rst_n,
        (!empty && !pop) |=> (!empty && $stable(o_normal_x) && $stable(o_normal_z)))

    // y comes from a positive component, never negative
    `HNG_ASSERT(a_y_nonneg, i_clk, i_rst_n, !empty |-> !o_normal_y[15])

    // only interior vertices are reported
    `HNG_ASSERT(a_interior, i_clk, i_rst_n,
        !empty |-> (o_vertex_row != 6'd0 && o_vertex_col != 6'd0))
endmodule

bind heightmap_normal_generator hng_checker u_hng_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_normal_x  (o_normal_x),
    .o_normal_y  (o_normal_y),
    .o_normal_z  (o_normal_z),
    .o_vertex_row(o_vertex_row),
    .o_vertex_col(o_vertex_col)
);
